// ===== sv/mlfp_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfp_pkg
// Shared types and constants for the magic/length frame parser.
// ----------------------------------------------------------------------------
package mlfp_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_WORD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd1;

  // "BHNP", first received byte in the top byte
  localparam logic [31:0] MAGIC_RESET   = 32'h4248_4E50;
  localparam logic [31:0] MAX_LEN_RESET = 32'(10 * 1024 * 1024);

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_OVERSIZE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic       frame_last;
  } res_t;

endpackage

// ===== sv/magic_length_frame_parser.sv =====
// ----------------------------------------------------------------------------
// magic_length_frame_parser
// Hunts a 4-byte magic word, gathers a 32-bit big-endian length and streams
// that many payload bytes, flagging empty and oversize frames.
// ----------------------------------------------------------------------------
//
//   channel | handshake               | payload
//   --------+-------------------------+-----------------------------------
//   in      | in_valid / in_stall     | in_byte, chunk_last
//   out     | out_valid / out_stall   | kind, data_byte, frame_last
//   cfg     | cfg_we (no back-press.) | cfg_index, cfg_data
//
// One byte per clock sustained while out_stall is low: a byte sits in the input
// register, the parser logic updates state and forms its result from it, and
// the result is captured in the output register as the state advances.
// Synchronous active-high reset returns to hunting with an empty window and
// restores the default magic word and maximum length.
// A stall on the output holds the result register and backs up into in_stall
// only while the input register is also full.
// chunk_last marks receive block boundaries and does not affect parsing.
// ----------------------------------------------------------------------------
module magic_length_frame_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mlfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlfp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_byte,
  input  logic                            chunk_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      kind,
  output logic [7:0]                      data_byte,
  output logic                            frame_last
);

  import mlfp_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       adv;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  // Input register: capture the byte, hold it while the result side is full.
  mlfp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_stall (in_stall),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  // Parser state machine and config registers; state advances on adv.
  mlfp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s1_valid  (s1_valid),
    .s1_byte   (s1_byte),
    .take      (adv),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: a byte that yields no result still advances here.
  mlfp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .res_valid (res_valid),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign kind       = out_res.kind;
  assign data_byte  = out_res.data_byte;
  assign frame_last = out_res.frame_last;

endmodule

// ===== sv/mlfp_in_stage.sv =====
// ----------------------------------------------------------------------------
// mlfp_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module mlfp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_stall,
  input  logic       adv,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic load;

  assign in_stall = s1_valid && !adv;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_byte <= in_byte;
    end
  end

endmodule

// ===== sv/mlfp_core.sv =====
// ----------------------------------------------------------------------------
// mlfp_core
// Parser state and the single-pass next-state / result logic.
// ----------------------------------------------------------------------------
module mlfp_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mlfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlfp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s1_valid,
  input  logic [7:0]                     s1_byte,
  input  logic                           take,
  output logic                           res_valid,
  output mlfp_pkg::res_t                 res
);

  import mlfp_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_LEN  = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  logic [31:0] magic_word;
  logic [31:0] max_length;

  phase_t      phase, phase_next;
  logic [23:0] hunt_window, hunt_window_next;
  logic [1:0]  byte_count, byte_count_next;
  logic [31:0] length_shift, length_shift_next;
  logic [31:0] remaining, remaining_next;

  logic [31:0] word;
  logic [31:0] len;
  logic        last;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word <= MAGIC_RESET;
      max_length <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAGIC_WORD: magic_word <= cfg_data;
        REG_MAX_LENGTH: max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign word = {hunt_window, s1_byte};
  assign len  = {length_shift[23:0], s1_byte};
  assign last = (remaining <= 32'd1);

  always_comb begin
    phase_next        = phase;
    hunt_window_next  = hunt_window;
    byte_count_next   = byte_count;
    length_shift_next = length_shift;
    remaining_next    = remaining;
    res_valid         = 1'b0;
    res               = '{kind: KIND_PAYLOAD, data_byte: 8'h00, frame_last: 1'b0};

    case (phase)
      PH_LEN: begin
        length_shift_next = len;
        if (byte_count != 2'd3) begin
          byte_count_next = byte_count + 2'd1;
        end else begin
          // all four length bytes in: decide drop, empty or payload
          byte_count_next   = 2'd0;
          length_shift_next = '0;
          if (len > max_length) begin
            phase_next = PH_HUNT;
            res_valid  = 1'b1;
            res        = '{kind: KIND_OVERSIZE, data_byte: 8'h00, frame_last: 1'b1};
          end else if (len == 32'd0) begin
            phase_next = PH_HUNT;
            res_valid  = 1'b1;
            res        = '{kind: KIND_EMPTY, data_byte: 8'h00, frame_last: 1'b1};
          end else begin
            phase_next     = PH_DATA;
            remaining_next = len;
          end
        end
      end
      PH_DATA: begin
        res_valid = 1'b1;
        res       = '{kind: KIND_PAYLOAD, data_byte: s1_byte, frame_last: last};
        if (last) begin
          phase_next     = PH_HUNT;
          remaining_next = '0;
        end else begin
          remaining_next = remaining - 32'd1;
        end
      end
      default: begin
        // hunting; slide the window once three bytes are held
        phase_next = PH_HUNT;
        if (byte_count == 2'd3) begin
          if (word == magic_word) begin
            phase_next       = PH_LEN;
            hunt_window_next = '0;
            byte_count_next  = 2'd0;
          end else begin
            hunt_window_next = word[23:0];
          end
        end else begin
          hunt_window_next = {hunt_window[15:0], s1_byte};
          byte_count_next  = byte_count + 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      hunt_window  <= '0;
      byte_count   <= '0;
      length_shift <= '0;
      remaining    <= '0;
    end else if (s1_valid && take) begin
      phase        <= phase_next;
      hunt_window  <= hunt_window_next;
      byte_count   <= byte_count_next;
      length_shift <= length_shift_next;
      remaining    <= remaining_next;
    end
  end

`ifndef SYNTHESIS
  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> remaining != 32'd0)
    else $error("payload phase with zero bytes remaining");

  a_last_rehunt: assert property (@(posedge clk) disable iff (rst)
    s1_valid && take && phase == PH_DATA && remaining <= 32'd1 |=> phase == PH_HUNT)
    else $error("no return to hunt after final payload byte");

  a_len_window_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LEN |-> hunt_window == 24'd0)
    else $error("hunt window not cleared in length phase");

  a_hunt_len_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HUNT |-> length_shift == 32'd0)
    else $error("length gather not cleared while hunting");
`endif

endmodule

// ===== sv/mlfp_out_stage.sv =====
// ----------------------------------------------------------------------------
// mlfp_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module mlfp_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           s1_valid,
  input  logic           res_valid,
  input  mlfp_pkg::res_t res,
  output logic           adv,
  output logic           out_valid,
  input  logic           out_stall,
  output mlfp_pkg::res_t out_res
);

  import mlfp_pkg::*;

  logic out_free;
  logic load;

  // register is free when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;
  assign adv      = s1_valid && out_free;
  assign load     = adv && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

// ===== tb/magic_length_frame_parser_tb.sv =====
// ----------------------------------------------------------------------------
// magic_length_frame_parser_tb
// Self-checking bench for the magic/length frame parser. A behavioral parser
// tracks every accepted stream byte and predicts payload, empty-frame and
// oversize results. Each result leaving the block is checked field by field.
// Traffic: a short directed stream, then random framed traffic with noise
// and broken frames, under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module magic_length_frame_parser_tb;
  import mlfp_pkg::*;

  // Register indexes beyond the defined pair; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
  localparam int SETTLE_CYCLES  = 6;     // margin for bytes still held in the input and result registers
  localparam int MAX_PRINTS     = 40;

  typedef enum logic [1:0] {
    ST_HUNT = 2'd0,
    ST_LEN  = 2'd1,
    ST_DATA = 2'd2
  } parse_state_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [7:0] value;
    logic       blk_end;
  } stream_byte_t;

  // --------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_byte    = 8'h00;
  logic                  chunk_last = 1'b0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [1:0]            kind;
  logic [7:0]            data_byte;
  logic                  frame_last;

  magic_length_frame_parser u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .chunk_last (chunk_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .data_byte  (data_byte),
    .frame_last (frame_last)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  stream_byte_t rx_stream_q[$];      // bytes waiting to be driven
  res_t         frame_results_q[$];  // predicted results, oldest first

  int tx_gap_pct    = 0;
  int rx_stall_pct  = 0;
  bit in_took       = 1'b0;
  bit out_took      = 1'b0;
  int quiet_cycles  = 0;
  int err_cnt       = 0;
  int bytes_queued  = 0;
  int bytes_taken   = 0;
  int payload_cnt   = 0;
  int empty_cnt     = 0;
  int oversize_cnt  = 0;
  int cfg_writes    = 0;

  // Shadow registers and parser state of the behavioral model
  logic [31:0]  cfg_magic      = MAGIC_RESET;
  logic [31:0]  cfg_max_length = MAX_LEN_RESET;
  parse_state_t pstate         = ST_HUNT;
  logic [23:0]  hunt_win       = '0;
  logic [1:0]   byte_cnt       = '0;
  logic [31:0]  len_acc        = '0;
  logic [31:0]  bytes_left     = '0;

  // --------------------------------------------------------------------------
  // Behavioral parser
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic expect_result(input kind_t k, input logic [7:0] d, input logic l);
    res_t r;
    r.kind       = k;
    r.data_byte  = d;
    r.frame_last = l;
    frame_results_q.push_back(r);
  endtask

  task automatic restart_hunt();
    pstate     = ST_HUNT;
    hunt_win   = '0;
    byte_cnt   = '0;
    len_acc    = '0;
    bytes_left = '0;
  endtask

  // Advance the model by one accepted stream byte.
  task automatic parse_byte(input logic [7:0] b);
    logic [31:0] word;
    logic        tail;
    case (pstate)
      ST_LEN: begin
        len_acc = {len_acc[23:0], b};
        if (byte_cnt < 2'd3) begin
          byte_cnt++;
        end else if (len_acc > cfg_max_length) begin
          // oversize check wins over the zero check
          restart_hunt();
          expect_result(KIND_OVERSIZE, 8'h00, 1'b1);
        end else if (len_acc == 32'd0) begin
          restart_hunt();
          expect_result(KIND_EMPTY, 8'h00, 1'b1);
        end else begin
          pstate     = ST_DATA;
          bytes_left = len_acc;
          byte_cnt   = '0;
          len_acc    = '0;
        end
      end
      ST_DATA: begin
        tail = (bytes_left <= 32'd1);
        expect_result(KIND_PAYLOAD, b, tail);
        if (tail) restart_hunt();
        else bytes_left--;
      end
      default: begin
        // hunting; an unused state value behaves the same
        if (byte_cnt == 2'd3) begin
          word = {hunt_win, b};
          if (word == cfg_magic) begin
            restart_hunt();
            pstate = ST_LEN;
          end else begin
            // drop the oldest byte and keep sliding
            hunt_win = word[23:0];
          end
        end else begin
          pstate   = ST_HUNT;
          hunt_win = {hunt_win[15:0], b};
          byte_cnt++;
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver: present one stream byte per transaction, change on falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_rx
    stream_byte_t nxt;
    // Advance only when the slot is empty or its byte was just taken;
    // the idle decision never looks at in_stall.
    if (!rst && (!in_valid || in_took)) begin
      if (rx_stream_q.size() != 0 && $urandom_range(0, 99) >= tx_gap_pct) begin
        nxt = rx_stream_q.pop_front();
        in_valid   <= 1'b1;
        in_byte    <= nxt.value;
        chunk_last <= nxt.blk_end;
      end else begin
        // idle slot: scramble the payload, it must be ignored
        in_valid   <= 1'b0;
        in_byte    <= 8'($urandom);
        chunk_last <= 1'($urandom);
      end
    end
    out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: sample on the rising edge, predict, check, watch for hangs
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_tx
    res_t want;
    if (rst) begin
      in_took  = 1'b0;
      out_took = 1'b0;
    end else begin
      in_took  = in_valid && !in_stall;
      out_took = out_valid && !out_stall;
      // Predict first so a result can never race its own input.
      if (in_took) begin
        parse_byte(in_byte);
        bytes_taken++;
      end
      if (out_took) begin
        if (frame_results_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind=%0d data=%02h last=%0b",
                                  kind, data_byte, frame_last));
        end else begin
          want = frame_results_q.pop_front();
          if (kind !== want.kind)
            flag_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
          if (data_byte !== want.data_byte)
            flag_mismatch($sformatf("data_byte %02h, expected %02h",
                                    data_byte, want.data_byte));
          if (frame_last !== want.frame_last)
            flag_mismatch($sformatf("frame_last %0b, expected %0b",
                                    frame_last, want.frame_last));
          case (want.kind)
            KIND_PAYLOAD:  payload_cnt++;
            KIND_EMPTY:    empty_cnt++;
            default:       oversize_cnt++;
          endcase
        end
      end
      if (in_took || out_took) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b);
    stream_byte_t sb;
    sb.value   = b;
    sb.blk_end = ($urandom_range(0, 3) == 0);
    rx_stream_q.push_back(sb);
    bytes_queued++;
  endtask

  // Big-endian: top byte goes first.
  task automatic queue_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) queue_byte(w[31 - 8*i -: 8]);
  endtask

  // Magic, length and, when the length is accepted, random payload.
  task automatic queue_frame(input logic [31:0] len);
    queue_word(cfg_magic);
    queue_word(len);
    if (len != 32'd0 && len <= cfg_max_length)
      repeat (len) queue_byte(8'($urandom));
  endtask

  // Mostly well-formed frames with random content; the rest is noise and
  // broken frames. Lengths stay small so frames are short. Broken length
  // fields are only used when max_length bounds any frame they create.
  task automatic queue_random_traffic(input int n);
    int          goal;
    int          pick;
    int          k;
    logic [31:0] len;
    goal = bytes_queued + n;
    while (bytes_queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        repeat ($urandom_range(0, 2)) queue_byte(8'($urandom));
        case ($urandom_range(0, 9))
          0: len = 32'd0;
          1: begin
            len = $urandom();
            if (len <= cfg_max_length)
              len = (cfg_max_length == '1) ? 32'($urandom_range(1, 12))
                                           : cfg_max_length + 32'd1;
          end
          default: len = 32'($urandom_range(1, 12));
        endcase
        queue_frame(len);
      end else if (pick < 86) begin
        repeat ($urandom_range(1, 6)) queue_byte(8'($urandom));
      end else begin
        k = $urandom_range(1, 3);
        if (cfg_max_length <= 32'd255 && $urandom_range(0, 1) == 1) begin
          // truncated length: whatever follows completes it
          queue_word(cfg_magic);
          for (int i = 0; i < k; i++) queue_byte(8'($urandom));
        end else begin
          // partial magic cut short by a byte that never matches the next one
          for (int i = 0; i < k; i++) queue_byte(cfg_magic[31 - 8*i -: 8]);
          queue_byte(cfg_magic[31 - 8*k -: 8] ^ 8'($urandom_range(1, 255)));
        end
      end
    end
  endtask

  task automatic set_idle(input idle_mode_t m);
    case (m)
      IDLE_SEND: begin tx_gap_pct = 73; rx_stall_pct = 0;  end
      IDLE_RECV: begin tx_gap_pct = 0;  rx_stall_pct = 73; end
      IDLE_BOTH: begin tx_gap_pct = 28; rx_stall_pct = 28; end
      default:   begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
    endcase
  endtask

  // Hold until every byte is taken and every predicted result has arrived,
  // then let the pipeline settle; a byte may still be in flight with no result.
  task automatic drain();
    while (rx_stream_q.size() != 0 || in_valid || frame_results_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_MAGIC_WORD) cfg_magic = val;
    else if (idx == REG_MAX_LENGTH) cfg_max_length = val;
    cfg_writes++;
  endtask

  task automatic run_phase(input idle_mode_t m, input int n);
    set_idle(m);
    @(posedge clk);
    queue_random_traffic(n);
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed stream under reset register values, no idling.
    // A stray first byte forces the window to slide before the magic lands.
    queue_byte(MAGIC_RESET[31:24]);
    queue_frame(32'd0);                   // empty frame
    queue_frame(MAX_LEN_RESET + 32'd1);   // one past the limit: oversize
    queue_word(cfg_magic);                // two payload bytes at the extremes
    queue_word(32'd2);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    drain();

    // Spare indexes must not disturb the reset values.
    write_reg(REG_SPARE_2, $urandom());
    write_reg(REG_SPARE_3, $urandom());
    run_phase(IDLE_NONE, 200);

    // All-zero magic, zero limit: only empty frames get through.
    write_reg(REG_MAGIC_WORD, 32'h0000_0000);
    write_reg(REG_MAX_LENGTH, 32'h0000_0000);
    run_phase(IDLE_SEND, 200);

    write_reg(REG_MAGIC_WORD, 32'hFFFF_FFFF);
    write_reg(REG_MAX_LENGTH, 32'd255);
    run_phase(IDLE_RECV, 250);

    // Full-range limit; magic with distinct bytes keeps frames aligned.
    // Pause the sender halfway until every result is back.
    write_reg(REG_MAGIC_WORD, 32'h0102_0380);
    write_reg(REG_MAX_LENGTH, 32'hFFFF_FFFF);
    run_phase(IDLE_BOTH, 125);
    run_phase(IDLE_BOTH, 125);

    write_reg(REG_MAGIC_WORD, $urandom());
    write_reg(REG_MAX_LENGTH, 32'($urandom_range(0, 64)));
    run_phase(idle_mode_t'($urandom_range(0, 3)), 200);

    write_reg(REG_MAGIC_WORD, MAGIC_RESET);
    write_reg(REG_MAX_LENGTH, 32'd12);
    run_phase(IDLE_RECV, 200);

    drain();
    if (frame_results_q.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived",
                              frame_results_q.size()));

    $display("Run covered %0d stream bytes and %0d register writes.",
             bytes_taken, cfg_writes);
    $display("Checked %0d payload bytes, %0d empty frames, %0d oversize drops; %0d errors.",
             payload_cnt, empty_cnt, oversize_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mlfp_pkg.sv
sv/mlfp_in_stage.sv
sv/mlfp_core.sv
sv/mlfp_out_stage.sv
sv/magic_length_frame_parser.sv
tb/magic_length_frame_parser_tb.sv
